// ----- design/rau_pkg.sv -----
// Shared types and constants of the rational arithmetic unit.
// No dependencies; used by rau_ctrl, rau_datapath and rational_arithmetic_unit.
package rau_pkg;

   localparam int OPERAND_WIDTH_DEF = 32;
   localparam int IN_W              = 32;
   localparam int RES_W             = 64;
   localparam int OP_W              = 3;
   localparam int CMP_W             = 2;
   localparam int CNT_W             = $clog2(RES_W);

   localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
   localparam logic [OP_W-1:0] OP_CMP  = 3'd4;
   localparam logic [OP_W-1:0] OP_SIMP = 3'd5;

   localparam logic [CMP_W-1:0] CMP_EQ = 2'b00;
   localparam logic [CMP_W-1:0] CMP_GT = 2'b01;
   localparam logic [CMP_W-1:0] CMP_LT = 2'b11;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_MUL1,
      DP_MUL2,
      DP_MUL3,
      DP_COMBINE,
      DP_GCD_TWO,
      DP_GCD_STEP,
      DP_DIV_INIT_N,
      DP_DIV_STEP,
      DP_DIV_NEXT,
      DP_OUT_INVALID,
      DP_OUT_CMP,
      DP_OUT_ZERO,
      DP_OUT_RED
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic inval;
      logic is_cmp;
      logic n_zero;
      logic both_even;
      logic u_zero;
   } dp_status_type;

endpackage

// ----- design/rau_ctrl.sv -----
// Sequencer of the rational arithmetic unit: steps the datapath through
// multiply, combine, binary GCD and two restoring divisions. Uses rau_pkg.
module rau_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rau_pkg::dp_status_type status,
   output rau_pkg::dp_cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_MUL1 = 12'b0000_0000_0010,
      S_MUL2 = 12'b0000_0000_0100,
      S_MUL3 = 12'b0000_0000_1000,
      S_COMB = 12'b0000_0001_0000,
      S_TWO  = 12'b0000_0010_0000,
      S_GCD  = 12'b0000_0100_0000,
      S_DIVN = 12'b0000_1000_0000,
      S_DMID = 12'b0001_0000_0000,
      S_DIVD = 12'b0010_0000_0000,
      S_FIN  = 12'b0100_0000_0000,
      S_DONE = 12'b1000_0000_0000
   } state_type;

   state_type                  state_ff, state_in;
   logic [rau_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       cnt_last;

   assign cnt_last  = (cnt_ff == rau_pkg::CNT_W'(rau_pkg::RES_W - 1));
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = rau_pkg::DP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.op   = rau_pkg::DP_LOAD;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            if (status.inval) begin
               cmd.op   = rau_pkg::DP_OUT_INVALID;
               state_in = S_DONE;
            end else begin
               cmd.op   = rau_pkg::DP_MUL1;
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            cmd.op   = rau_pkg::DP_MUL2;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            cmd.op   = rau_pkg::DP_MUL3;
            state_in = S_COMB;
         end
         S_COMB: begin
            if (status.is_cmp) begin
               cmd.op   = rau_pkg::DP_OUT_CMP;
               state_in = S_DONE;
            end else begin
               cmd.op   = rau_pkg::DP_COMBINE;
               state_in = S_TWO;
            end
         end
         S_TWO: begin
            if (status.n_zero) begin
               cmd.op   = rau_pkg::DP_OUT_ZERO;
               state_in = S_DONE;
            end else if (status.both_even) begin
               cmd.op = rau_pkg::DP_GCD_TWO;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (status.u_zero) begin
               cmd.op   = rau_pkg::DP_DIV_INIT_N;
               cnt_in   = '0;
               state_in = S_DIVN;
            end else begin
               cmd.op = rau_pkg::DP_GCD_STEP;
            end
         end
         S_DIVN: begin
            cmd.op = rau_pkg::DP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) state_in = S_DMID;
         end
         S_DMID: begin
            cmd.op   = rau_pkg::DP_DIV_NEXT;
            cnt_in   = '0;
            state_in = S_DIVD;
         end
         S_DIVD: begin
            cmd.op = rau_pkg::DP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = rau_pkg::DP_OUT_RED;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- design/rau_datapath.sv -----
// Datapath of the rational arithmetic unit: operand registers, shared
// multiplier, binary GCD and restoring divider. Uses rau_pkg.
module rau_datapath #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                              clock,
   input  rau_pkg::dp_cmd_type               cmd,
   output rau_pkg::dp_status_type            status,
   input  logic [rau_pkg::OP_W-1:0]          in_type,
   input  logic [rau_pkg::IN_W-1:0]          in_a_num,
   input  logic [rau_pkg::IN_W-1:0]          in_a_den,
   input  logic [rau_pkg::IN_W-1:0]          in_b_num,
   input  logic [rau_pkg::IN_W-1:0]          in_b_den,
   output logic signed [rau_pkg::RES_W-1:0]  res_num,
   output logic signed [rau_pkg::RES_W-1:0]  res_den,
   output logic [rau_pkg::CMP_W-1:0]         cmp_result,
   output logic                              res_status
);

   localparam int W  = OPERAND_WIDTH;
   localparam int RW = rau_pkg::RES_W;
   localparam int KW = $clog2(RW) + 1;

   logic [rau_pkg::OP_W-1:0] op_ff, op_in;
   logic [W-1:0]  an_ff, ad_ff, bn_ff, bd_ff, an_in, ad_in, bn_in, bd_in;
   logic [RW-1:0] t1_ff, t2_ff, den_ff, n_ff, u_ff, v_ff, g_ff, quo_ff, qn_ff;
   logic [RW-1:0] t1_in, t2_in, den_in, n_in, u_in, v_in, g_in, quo_in, qn_in;
   logic [RW:0]   rem_ff, rem_in;
   logic          neg_ff, neg_in;
   logic [KW-1:0] k_ff, k_in;
   logic [RW-1:0] rn_ff, rd_ff, rn_in, rd_in;
   logic [rau_pkg::CMP_W-1:0] cmp_ff, cmp_in;
   logic          st_ff, st_in;

   logic [W:0]       an_x, ad_x, bn_x, bd_x, ma, mad, mb, mbd, mul_x, mul_y;
   logic [2*W+1:0]   prod;
   logic             neg_a, neg_b, s1, s2;
   logic signed [RW-1:0] cx, cy;
   logic [RW:0]      dr;
   logic             dge;

   // magnitudes and signs of the held operands
   assign an_x  = {an_ff[W-1], an_ff};
   assign ad_x  = {ad_ff[W-1], ad_ff};
   assign bn_x  = {bn_ff[W-1], bn_ff};
   assign bd_x  = {bd_ff[W-1], bd_ff};
   assign ma    = an_ff[W-1] ? (~an_x + 1'b1) : an_x;
   assign mad   = ad_ff[W-1] ? (~ad_x + 1'b1) : ad_x;
   assign mb    = bn_ff[W-1] ? (~bn_x + 1'b1) : bn_x;
   assign mbd   = bd_ff[W-1] ? (~bd_x + 1'b1) : bd_x;
   assign neg_a = an_ff[W-1] ^ ad_ff[W-1];
   assign neg_b = bn_ff[W-1] ^ bd_ff[W-1];

   // operand select for the shared multiplier
   always_comb begin
      mul_x = ma;
      mul_y = mbd;
      case (cmd.op)
         rau_pkg::DP_MUL1: begin
            mul_x = ma;
            if (op_ff == rau_pkg::OP_MUL)       mul_y = mb;
            else if (op_ff == rau_pkg::OP_SIMP) mul_y = (W+1)'(1);
            else                                mul_y = mbd;
         end
         rau_pkg::DP_MUL2: begin
            mul_x = mb;
            mul_y = mad;
         end
         rau_pkg::DP_MUL3: begin
            mul_x = mad;
            if (op_ff == rau_pkg::OP_DIV)       mul_y = mb;
            else if (op_ff == rau_pkg::OP_SIMP) mul_y = (W+1)'(1);
            else                                mul_y = mbd;
         end
         default: begin
            mul_x = ma;
            mul_y = mbd;
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   assign s1 = neg_a && (t1_ff != '0);
   assign s2 = ((op_ff == rau_pkg::OP_SUB) ? !neg_b : neg_b) && (t2_ff != '0);
   assign cx = neg_a ? -$signed(t1_ff) : $signed(t1_ff);
   assign cy = neg_b ? -$signed(t2_ff) : $signed(t2_ff);

   assign dr  = {rem_ff[RW-1:0], quo_ff[RW-1]};
   assign dge = (dr >= {1'b0, g_ff});

   assign status.inval = (op_ff > rau_pkg::OP_SIMP) || (ad_ff == '0) ||
                         ((op_ff != rau_pkg::OP_SIMP) &&
                          ((bd_ff == '0) || ((op_ff == rau_pkg::OP_DIV) && (bn_ff == '0))));
   assign status.is_cmp    = (op_ff == rau_pkg::OP_CMP);
   assign status.n_zero    = (n_ff == '0);
   assign status.both_even = !u_ff[0] && !v_ff[0];
   assign status.u_zero    = (u_ff == '0);

   always_comb begin
      op_in  = op_ff;
      an_in  = an_ff;
      ad_in  = ad_ff;
      bn_in  = bn_ff;
      bd_in  = bd_ff;
      t1_in  = t1_ff;
      t2_in  = t2_ff;
      den_in = den_ff;
      n_in   = n_ff;
      neg_in = neg_ff;
      u_in   = u_ff;
      v_in   = v_ff;
      k_in   = k_ff;
      g_in   = g_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      qn_in  = qn_ff;
      rn_in  = rn_ff;
      rd_in  = rd_ff;
      cmp_in = cmp_ff;
      st_in  = st_ff;
      case (cmd.op)
         rau_pkg::DP_LOAD: begin
            op_in = in_type;
            an_in = in_a_num[W-1:0];
            ad_in = in_a_den[W-1:0];
            bn_in = in_b_num[W-1:0];
            bd_in = in_b_den[W-1:0];
         end
         rau_pkg::DP_MUL1: t1_in  = RW'(prod);
         rau_pkg::DP_MUL2: t2_in  = RW'(prod);
         rau_pkg::DP_MUL3: den_in = RW'(prod);
         rau_pkg::DP_COMBINE: begin
            if (op_ff == rau_pkg::OP_ADD || op_ff == rau_pkg::OP_SUB) begin
               if (s1 == s2) begin
                  n_in   = t1_ff + t2_ff;
                  neg_in = s1;
               end else if (t1_ff >= t2_ff) begin
                  n_in   = t1_ff - t2_ff;
                  neg_in = s1;
               end else begin
                  n_in   = t2_ff - t1_ff;
                  neg_in = s2;
               end
            end else begin
               n_in   = t1_ff;
               neg_in = (op_ff == rau_pkg::OP_SIMP) ? neg_a : (neg_a ^ neg_b);
            end
            u_in = n_in;
            v_in = den_ff;
            k_in = '0;
         end
         rau_pkg::DP_GCD_TWO: begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + 1'b1;
         end
         rau_pkg::DP_GCD_STEP: begin
            if (!u_ff[0])          u_in = u_ff >> 1;
            else if (!v_ff[0])     v_in = v_ff >> 1;
            else if (u_ff >= v_ff) u_in = (u_ff - v_ff) >> 1;
            else                   v_in = (v_ff - u_ff) >> 1;
         end
         rau_pkg::DP_DIV_INIT_N: begin
            g_in   = v_ff << k_ff;
            quo_in = n_ff;
            rem_in = '0;
         end
         rau_pkg::DP_DIV_STEP: begin
            rem_in = dge ? (dr - {1'b0, g_ff}) : dr;
            quo_in = {quo_ff[RW-2:0], dge};
         end
         rau_pkg::DP_DIV_NEXT: begin
            qn_in  = quo_ff;
            quo_in = den_ff;
            rem_in = '0;
         end
         rau_pkg::DP_OUT_INVALID: begin
            rn_in  = (op_ff == rau_pkg::OP_SIMP) ? {{(RW-W){an_ff[W-1]}}, an_ff} : '0;
            rd_in  = (op_ff == rau_pkg::OP_SIMP) ? {{(RW-W){ad_ff[W-1]}}, ad_ff} : '0;
            cmp_in = rau_pkg::CMP_EQ;
            st_in  = 1'b1;
         end
         rau_pkg::DP_OUT_CMP: begin
            rn_in = '0;
            rd_in = '0;
            if (cx < cy)      cmp_in = rau_pkg::CMP_LT;
            else if (cx > cy) cmp_in = rau_pkg::CMP_GT;
            else              cmp_in = rau_pkg::CMP_EQ;
            st_in = 1'b0;
         end
         rau_pkg::DP_OUT_ZERO: begin
            rn_in  = '0;
            rd_in  = RW'(1);
            cmp_in = rau_pkg::CMP_EQ;
            st_in  = 1'b0;
         end
         rau_pkg::DP_OUT_RED: begin
            rn_in  = neg_ff ? (~qn_ff + 1'b1) : qn_ff;
            rd_in  = quo_ff;
            cmp_in = rau_pkg::CMP_EQ;
            st_in  = 1'b0;
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      an_ff  <= an_in;
      ad_ff  <= ad_in;
      bn_ff  <= bn_in;
      bd_ff  <= bd_in;
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      den_ff <= den_in;
      n_ff   <= n_in;
      neg_ff <= neg_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      k_ff   <= k_in;
      g_ff   <= g_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      qn_ff  <= qn_in;
      rn_ff  <= rn_in;
      rd_ff  <= rd_in;
      cmp_ff <= cmp_in;
      st_ff  <= st_in;
   end

   assign res_num    = rn_ff;
   assign res_den    = rd_ff;
   assign cmp_result = cmp_ff;
   assign res_status = st_ff;

endmodule

// ----- design/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: one request at a time, one result per request.
// Invalid requests, compares and zero results finish early; any other request runs the
// multiplies, a binary GCD (shared factors of two removed first, then binary GCD steps)
// and then two 64-step restoring divisions that reduce the numerator and denominator.
// A new request is taken only after the response handshake and the return to idle.
// Reset (synchronous, active high) idles the sequencer; no result is pending.
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
   input  logic [2:0]   req_tuser,  // req_type[2:0]
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,  // res_num[63:0], res_den[127:64], cmp_result[129:128], zero pad
   output logic [0:0]   rsp_tuser   // status[0]
);

   rau_pkg::dp_cmd_type    cmd;
   rau_pkg::dp_status_type dp_status;
   logic                   req_fire;
   logic signed [rau_pkg::RES_W-1:0] res_num, res_den;
   logic [rau_pkg::CMP_W-1:0]        cmp_result;
   logic                             res_status;

   // accept a request only while the sequencer is idle
   assign req_fire = req_tvalid && req_tready;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   rau_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .status     (dp_status),
      .in_type    (req_tuser),
      .in_a_num   (req_tdata[31:0]),
      .in_a_den   (req_tdata[63:32]),
      .in_b_num   (req_tdata[95:64]),
      .in_b_den   (req_tdata[127:96]),
      .res_num    (res_num),
      .res_den    (res_den),
      .cmp_result (cmp_result),
      .res_status (res_status)
   );

   // hold the result registers steady while the response waits
   assign rsp_tdata = {6'b0, cmp_result, res_den, res_num};
   assign rsp_tuser = res_status;

endmodule
